/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising edge outside reset
`define SWTA_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);
// Check that a condition never holds outside reset
`define SWTA_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error(msg);
`else
`define SWTA_ASSERT(lbl, clk, rstn, prop, msg)
`define SWTA_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

/* hw/rtl/swta_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Token admission package
// Shared widths, codes, types and constants of the token admission unit.
// ----------------------------------------------------------------------------
package swta_pkg;

    // Table size and derived widths
    localparam int TABLE_DEPTH = 64;
    localparam int CNT_W       = $clog2(TABLE_DEPTH);

    // Field widths
    localparam int TIME_W = 32;
    localparam int TOK_W  = 24;
    localparam int WIN_W  = 22;
    localparam int WAIT_W = 17;
    localparam int WSUM_W = 30;
    localparam int IDX_W  = 2;

    // Exact window sum and the width used for fit and saturation
    localparam int SUM_W  = TOK_W + $clog2(TABLE_DEPTH);
    localparam int SUMX_W = (SUM_W > WSUM_W) ? SUM_W : WSUM_W;
    localparam int SUMF_W = SUMX_W + 1;

    // Wait limits in ms
    localparam int unsigned MIN_WAIT_MS   = 50;
    localparam int unsigned MAX_WAIT_MS   = 120000;
    localparam int unsigned WAIT_GUARD_MS = 1;
    localparam int unsigned WINDOW_RST_MS = 60000;

    // Request codes
    localparam logic ACT_CHECK  = 1'b0;
    localparam logic ACT_RECORD = 1'b1;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_BUDGET   = 2'd0;
    localparam logic [IDX_W-1:0] REG_HEADROOM = 2'd1;
    localparam logic [IDX_W-1:0] REG_WINDOW   = 2'd2;

    // One usage record as held in a cell
    typedef struct packed {
        logic              valid;
        logic [TIME_W-1:0] time_ms;
        logic [TOK_W-1:0]  tok;
    } slot_t;

    // Configuration seen by the controller
    typedef struct packed {
        logic [TOK_W-1:0] budget;
        logic [TOK_W-1:0] headroom;
        logic [WIN_W-1:0] window_ms;
    } cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } swta_state_t;

endpackage

/* hw/rtl/swta_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Record cell
// Holds one usage record and passes it to its neighbour on every shift.
// ----------------------------------------------------------------------------
module swta_cell
    import swta_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  shift,
    input  slot_t rec_in,
    output slot_t rec_out
);

    logic              valid_reg;
    logic [TIME_W-1:0] time_reg;
    logic [TOK_W-1:0]  tok_reg;

    // Clear the valid flag at reset, take the neighbour's flag on shift
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift)
        begin
            valid_reg <= rec_in.valid;
        end
    end

    // Advance the payload on shift
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            time_reg <= rec_in.time_ms;
            tok_reg  <= rec_in.tok;
        end
    end

    assign rec_out.valid   = valid_reg;
    assign rec_out.time_ms = time_reg;
    assign rec_out.tok     = tok_reg;

endmodule

/* hw/rtl/swta_ctrl.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// Admission controller
// Rotates the record chain once per scanned request, prunes, sums and places records.
// ----------------------------------------------------------------------------
module swta_ctrl
    import swta_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              action,
    input  logic [TIME_W-1:0] now_ms,
    input  logic [TOK_W-1:0]  tokens,
    input  cfg_t              cfg,
    input  slot_t             head,
    output slot_t             tail,
    output logic              shift,
    output logic              busy,
    output logic              done,
    output logic              admitted,
    output logic              over_cap_empty,
    output logic [WAIT_W-1:0] wait_ms,
    output logic [WSUM_W-1:0] recent_sum,
    output logic              record_refused
);

    swta_state_t       state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic              action_reg, action_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic [TOK_W-1:0]  tok_reg, tok_next;
    logic [TOK_W-1:0]  cap_reg, cap_next;
    logic              bypass_reg, bypass_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [WIN_W-1:0]  maxage_reg, maxage_next;
    logic              any_reg, any_next;
    logic              placed_reg, placed_next;
    logic              adm_reg, adm_next;
    logic              over_reg, over_next;
    logic [WAIT_W-1:0] wait_reg, wait_next;
    logic [WSUM_W-1:0] wsum_reg, wsum_next;
    logic              refused_reg, refused_next;

    logic [TIME_W-1:0] age;
    logic              live;
    logic [TOK_W-1:0]  cap_in;
    logic [SUMX_W-1:0] sum_x;
    logic              fit;
    logic [WIN_W:0]    wait_raw;

    // Age of the record at the head of the chain and its expiry
    assign age  = now_reg - head.time_ms;
    assign live = head.valid && (age <= TIME_W'(cfg.window_ms));

    // Cap is budget less headroom, floored at zero
    assign cap_in = (cfg.budget > cfg.headroom) ? (cfg.budget - cfg.headroom) : '0;

    // Closing arithmetic on the accumulated window
    assign sum_x    = SUMX_W'(sum_reg);
    assign fit      = ({1'b0, sum_x} + SUMF_W'(tok_reg)) <= SUMF_W'(cap_reg);
    assign wait_raw = {1'b0, cfg.window_ms} - {1'b0, maxage_reg}
                      + (WIN_W + 1)'(WAIT_GUARD_MS);

    // State and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    // Request, accumulator and result registers
    always_ff @(posedge clk)
    begin
        action_reg  <= action_next;
        now_reg     <= now_next;
        tok_reg     <= tok_next;
        cap_reg     <= cap_next;
        bypass_reg  <= bypass_next;
        sum_reg     <= sum_next;
        maxage_reg  <= maxage_next;
        any_reg     <= any_next;
        placed_reg  <= placed_next;
        adm_reg     <= adm_next;
        over_reg    <= over_next;
        wait_reg    <= wait_next;
        wsum_reg    <= wsum_next;
        refused_reg <= refused_next;
    end

    // Next state and outputs
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        done_next    = 1'b0;
        action_next  = action_reg;
        now_next     = now_reg;
        tok_next     = tok_reg;
        cap_next     = cap_reg;
        bypass_next  = bypass_reg;
        sum_next     = sum_reg;
        maxage_next  = maxage_reg;
        any_next     = any_reg;
        placed_next  = placed_reg;
        adm_next     = adm_reg;
        over_next    = over_reg;
        wait_next    = wait_reg;
        wsum_next    = wsum_reg;
        refused_next = refused_reg;
        shift        = 1'b0;
        tail         = head;

        case (state_reg)
            ST_IDLE:
            begin
                // Latch the request and clear the accumulators
                if (start)
                begin
                    action_next = action;
                    now_next    = now_ms;
                    tok_next    = tokens;
                    cap_next    = cap_in;
                    if (action == ACT_CHECK)
                    begin
                        bypass_next = (cap_in == '0) || (tokens == '0);
                    end
                    else
                    begin
                        bypass_next = (tokens == '0);
                    end
                    sum_next    = '0;
                    maxage_next = '0;
                    any_next    = 1'b0;
                    placed_next = 1'b0;
                    cnt_next    = CNT_W'(TABLE_DEPTH - 1);
                    if (bypass_next)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // Rotate one record past the head per cycle
                shift = 1'b1;
                if (action_reg == ACT_CHECK)
                begin
                    // Drop expired records, sum and age the rest
                    tail.valid = live;
                    if (live)
                    begin
                        sum_next = sum_reg + SUM_W'(head.tok);
                        any_next = 1'b1;
                        if (age[WIN_W-1:0] > maxage_reg)
                        begin
                            maxage_next = age[WIN_W-1:0];
                        end
                    end
                end
                else if (!placed_reg && !live)
                begin
                    // Place the record in the first free or expired slot
                    tail.valid   = 1'b1;
                    tail.time_ms = now_reg;
                    tail.tok     = tok_reg;
                    placed_next  = 1'b1;
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                // Form the result
                adm_next     = 1'b0;
                over_next    = 1'b0;
                wait_next    = '0;
                wsum_next    = '0;
                refused_next = 1'b0;
                if (action_reg == ACT_CHECK)
                begin
                    if (bypass_reg)
                    begin
                        adm_next = 1'b1;
                    end
                    else
                    begin
                        if (sum_x > SUMX_W'({WSUM_W{1'b1}}))
                        begin
                            wsum_next = {WSUM_W{1'b1}};
                        end
                        else
                        begin
                            wsum_next = sum_x[WSUM_W-1:0];
                        end
                        if (fit)
                        begin
                            adm_next = 1'b1;
                        end
                        else if (!any_reg)
                        begin
                            adm_next  = 1'b1;
                            over_next = 1'b1;
                        end
                        else if (wait_raw < (WIN_W + 1)'(MIN_WAIT_MS))
                        begin
                            wait_next = WAIT_W'(MIN_WAIT_MS);
                        end
                        else if (wait_raw > (WIN_W + 1)'(MAX_WAIT_MS))
                        begin
                            wait_next = WAIT_W'(MAX_WAIT_MS);
                        end
                        else
                        begin
                            wait_next = wait_raw[WAIT_W-1:0];
                        end
                    end
                end
                else
                begin
                    refused_next = !bypass_reg && !placed_reg;
                end
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy           = (state_reg != ST_IDLE);
    assign done           = done_reg;
    assign admitted       = adm_reg;
    assign over_cap_empty = over_reg;
    assign wait_ms        = wait_reg;
    assign recent_sum     = wsum_reg;
    assign record_refused = refused_reg;

    `SWTA_ASSERT(a_done_after_finish, clk, rst_n,
                 done_reg |-> $past(state_reg == ST_FINISH),
                 "result strobe without finishing step")
    `SWTA_ASSERT(a_admit_no_wait, clk, rst_n,
                 (done_reg && adm_reg) |-> (wait_reg == '0),
                 "admitted request carries a wait")
    `SWTA_ASSERT(a_over_admitted, clk, rst_n,
                 (done_reg && over_reg) |-> adm_reg,
                 "over-cap flag without admission")
    `SWTA_NEVER(a_refused_admit, clk, rst_n,
                done_reg && refused_reg && adm_reg,
                "refused record reported as admitted")
    `SWTA_ASSERT(a_start_busy, clk, rst_n,
                 (start && !busy) |=> busy,
                 "accepted request did not raise busy")

endmodule

/* hw/rtl/sliding_window_token_admission_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding-window token admission unit
// Flow: a request is latched in idle, scanned past every slot, then finished; a
//   check with zero cap or zero estimate, or a record of zero tokens, skips the scan.
// A new request is taken only while idle (busy low), the record chain rotating
//   once past the single compare-and-sum head per scanned request.
// Reset: all records invalid, budget and headroom 0, window 60000 ms; no
//   clearing pass. The receiver cannot stall: done is a one-cycle strobe.
// ----------------------------------------------------------------------------
module sliding_window_token_admission_unit
    import swta_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr,
    input  logic [IDX_W-1:0]  cfg_idx,
    input  logic [TOK_W-1:0]  cfg_data,
    input  logic              start,
    output logic              busy,
    input  logic              action,
    input  logic [TIME_W-1:0] now_ms,
    input  logic [TOK_W-1:0]  tokens,
    output logic              done,
    output logic              admitted,
    output logic              over_cap_empty,
    output logic [WAIT_W-1:0] wait_ms,
    output logic [WSUM_W-1:0] recent_sum,
    output logic              record_refused
);

    logic [TOK_W-1:0] budget_reg;
    logic [TOK_W-1:0] headroom_reg;
    logic [WIN_W-1:0] window_reg;
    cfg_t             cfg;
    slot_t            link [0:TABLE_DEPTH];
    slot_t            tail_rec;
    logic             shift;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            budget_reg   <= '0;
            headroom_reg <= '0;
            window_reg   <= WIN_W'(WINDOW_RST_MS);
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_BUDGET:   budget_reg   <= cfg_data;
                REG_HEADROOM: headroom_reg <= cfg_data;
                REG_WINDOW:   window_reg   <= cfg_data[WIN_W-1:0];
                default:      ;
            endcase
        end
    end

    assign cfg.budget    = budget_reg;
    assign cfg.headroom  = headroom_reg;
    assign cfg.window_ms = window_reg;

    // Record chain: cell i takes from cell i+1, the tail takes the head's update
    assign link[TABLE_DEPTH] = tail_rec;

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        swta_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .shift   (shift),
            .rec_in  (link[i + 1]),
            .rec_out (link[i])
        );
    end

    // Controller at the head of the chain
    swta_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .action         (action),
        .now_ms         (now_ms),
        .tokens         (tokens),
        .cfg            (cfg),
        .head           (link[0]),
        .tail           (tail_rec),
        .shift          (shift),
        .busy           (busy),
        .done           (done),
        .admitted       (admitted),
        .over_cap_empty (over_cap_empty),
        .wait_ms        (wait_ms),
        .recent_sum     (recent_sum),
        .record_refused (record_refused)
    );

endmodule
